FILE: sv/bid_pkg.sv
// Shared types and constants of the intra/inter mode decision block.
package bid_pkg;

	localparam int PIX_W = 8;
	localparam int DELTA_W = 9;
	localparam int COST_W = 14;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

FILE: sv/bid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/bid_alu.sv
// Shared compare, absolute-difference and accumulate unit.
module bid_alu #(
	parameter int W = 14
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] acc,
	output logic [W-1:0] diff,
	output logic [W-1:0] total
);

	logic ge;

	always_comb begin
		ge = (a >= b);
		diff = ge ? (a - b) : (b - a);
		total = acc + diff;
	end

endmodule

FILE: sv/block_intra_inter_decision.sv
// Top level of the intra/inter mode decision block with its sequencer.
// Each pixel beat is answered by one result beat carrying the signed
// difference; a result beat that is held off stalls the input. After the last pixel of a
// block of BLOCK_SIDE*BLOCK_SIDE = N pixels the block stops taking beats: it finds the
// truncated mean by a reciprocal multiplication, walks the pixel store through its single
// read port, and posts the decision before it takes the next block's pixels.
// The difference sums of the load and of the walk run on one shared compare and accumulate
// unit.
module block_intra_inter_decision #(
	parameter int BLOCK_SIDE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: cur_pixel[7:0], ref_pixel[15:8].
	input  logic [bid_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: delta[8:0], intra_cost[22:9], inter_cost[36:23], zero pad.
	output logic [bid_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// Fields from bit 0: is_intra[0].
	output logic [bid_pkg::M_TUSER_W-1:0]  m_tuser
);

	import bid_pkg::*;

	localparam int NPIX = BLOCK_SIDE * BLOCK_SIDE;
	localparam int IDX_W = $clog2(NPIX);
	localparam int CNT_W = $clog2(NPIX + 1);
	localparam int SUM_W = $clog2(NPIX * ((1 << PIX_W) - 1) + 1);
	localparam int RECIP_SH = SUM_W + $clog2(NPIX);
	localparam longint RECIP = ((longint'(1) << RECIP_SH) + longint'(NPIX) - 1)
		/ longint'(NPIX);
	localparam int PROD_W = RECIP_SH + PIX_W;

	state_t               state_q;
	logic [IDX_W-1:0]     pix_idx_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     sad_q;
	logic [SUM_W-1:0]     cost_q;
	logic [PIX_W-1:0]     mean_q;
	logic [CNT_W-1:0]     walk_q;
	logic                 rd_vld_q;
	logic [DELTA_W-1:0]   last_delta_q;

	logic                 m_tvalid_q;
	logic [DELTA_W-1:0]   delta_q;
	logic                 done_q;
	logic                 intra_q;
	logic [COST_W-1:0]    intra_cost_q;
	logic [COST_W-1:0]    inter_cost_q;

	logic [PIX_W-1:0]     cur_pix;
	logic [PIX_W-1:0]     ref_pix;
	logic [DELTA_W-1:0]   delta;
	logic                 s_accept;
	logic                 last_pix;
	logic                 out_free;
	logic                 out_load;
	logic [PIX_W-1:0]     rd_data;
	logic [PROD_W-1:0]    mean_prod;

	logic [SUM_W-1:0]     alu_a;
	logic [SUM_W-1:0]     alu_b;
	logic [SUM_W-1:0]     alu_acc;
	logic [SUM_W-1:0]     alu_diff;
	logic [SUM_W-1:0]     alu_total;

	assign cur_pix = s_tdata[PIX_W-1:0];
	assign ref_pix = s_tdata[2*PIX_W-1:PIX_W];
	assign delta = {1'b0, cur_pix} - {1'b0, ref_pix};
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_LOAD) && out_free;
	assign s_accept = s_tvalid && s_tready;
	assign last_pix = (pix_idx_q == IDX_W'(NPIX - 1));
	assign out_load = (s_accept && !last_pix) || ((state_q == ST_EMIT) && out_free);
	assign mean_prod = PROD_W'(sum_q) * PROD_W'(RECIP);

	bid_ram #(
		.WIDTH(PIX_W),
		.DEPTH(NPIX)
	) u_pix_store (
		.clk    (clk),
		.wr_en  (s_accept),
		.wr_addr(pix_idx_q),
		.wr_data(cur_pix),
		.rd_addr(walk_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		unique case (state_q)
			ST_LOAD: begin
				alu_a = SUM_W'(cur_pix);
				alu_b = SUM_W'(ref_pix);
				alu_acc = sad_q;
			end
			ST_WALK: begin
				alu_a = SUM_W'(rd_data);
				alu_b = SUM_W'(mean_q);
				alu_acc = cost_q;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
				alu_acc = '0;
			end
		endcase
	end

	bid_alu #(
		.W(SUM_W)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.acc  (alu_acc),
		.diff (alu_diff),
		.total(alu_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pix_idx_q <= '0;
			sum_q <= '0;
			sad_q <= '0;
			cost_q <= '0;
			mean_q <= '0;
			walk_q <= '0;
			rd_vld_q <= 1'b0;
			last_delta_q <= '0;
			m_tvalid_q <= 1'b0;
			delta_q <= '0;
			done_q <= 1'b0;
			intra_q <= 1'b0;
			intra_cost_q <= '0;
			inter_cost_q <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (s_accept) begin
						sum_q <= sum_q + SUM_W'(cur_pix);
						sad_q <= alu_total;
						if (last_pix) begin
							pix_idx_q <= '0;
							last_delta_q <= delta;
							state_q <= ST_DIV;
						end else begin
							pix_idx_q <= pix_idx_q + 1'b1;
							delta_q <= delta;
							done_q <= 1'b0;
							intra_q <= 1'b0;
							intra_cost_q <= '0;
							inter_cost_q <= '0;
						end
					end
				end
				ST_DIV: begin
					mean_q <= mean_prod[PROD_W-1 -: PIX_W];
					walk_q <= '0;
					cost_q <= '0;
					rd_vld_q <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					rd_vld_q <= (walk_q != CNT_W'(NPIX));
					if (rd_vld_q) begin
						cost_q <= alu_total;
					end
					if (walk_q == CNT_W'(NPIX)) begin
						state_q <= ST_EMIT;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						delta_q <= last_delta_q;
						done_q <= 1'b1;
						intra_q <= (cost_q <= sad_q);
						intra_cost_q <= COST_W'(cost_q);
						inter_cost_q <= COST_W'(sad_q);
						sum_q <= '0;
						sad_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {
		(M_TDATA_W - DELTA_W - 2 * COST_W)'(0), inter_cost_q, intra_cost_q, delta_q
	};
	assign m_tlast = done_q;
	assign m_tuser = intra_q;

	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && last_pix) |=> (state_q == ST_DIV))
		else $error("Last pixel beat did not start the mean computation.");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_q <= CNT_W'(NPIX)))
		else $error("Walk counter ran past the pixel count.");

	a_done_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (pix_idx_q == '0))
		else $error("Pixel index not cleared while the block result is pending.");

endmodule
